### hdl/lks_pkg.sv
package lks_pkg;

  localparam int NODE_COUNT_DEF = 1024;

  localparam logic [15:0] END_MARK = 16'hFFFF;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // APB map: one 32-bit register per word
  localparam int          PADDR_W       = 3;
  localparam logic [0:0]  REG_LIST_HEAD = 1'b0;

  typedef struct packed {
    logic        func;
    logic [9:0]  node_index;
    logic [31:0] key_high;
    logic [31:0] key_low;
    logic [15:0] next_index;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [15:0] found_index;
    logic [15:0] prev_index;
  } rsp_t;

  typedef struct packed {
    logic [31:0] key_high;
    logic [31:0] key_low;
    logic [15:0] successor;
  } node_t;

  // walker -> output stage
  typedef struct packed {
    logic valid;
    rsp_t rsp;
  } walk_res_t;

endpackage

### hdl/lks_node_store.sv
module lks_node_store #(
  parameter int NODE_COUNT = lks_pkg::NODE_COUNT_DEF,
  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  lks_pkg::node_t       wr_data,
  input  logic [AW-1:0]        rd_addr,
  output lks_pkg::node_t       rd_data
);

  lks_pkg::node_t mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/lks_walker.sv
module lks_walker #(
  parameter int NODE_COUNT = lks_pkg::NODE_COUNT_DEF,
  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1,
  localparam int CW = $clog2(NODE_COUNT + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        list_head,
  input  logic               req_valid,
  output logic               req_ready,
  input  lks_pkg::req_t      req,
  output lks_pkg::walk_res_t res,
  input  logic               res_ready
);

  typedef enum logic [1:0] {ST_IDLE, ST_VISIT, ST_DONE} state_t;

  state_t          state;
  logic [15:0]     cur;
  logic [15:0]     prev;
  logic [CW-1:0]   visits;
  logic [31:0]     key_high;
  logic [31:0]     key_low;
  lks_pkg::rsp_t   result;

  logic            wr_en;
  logic [15:0]     wr_idx;
  lks_pkg::node_t  wr_data;
  logic [AW-1:0]   rd_addr;
  lks_pkg::node_t  rd_data;

  logic            accept;
  logic            hit;
  logic [15:0]     nxt;
  logic            head_ok;
  logic            nxt_ok;
  lks_pkg::rsp_t   miss;

  lks_node_store #(.NODE_COUNT(NODE_COUNT)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;

  assign wr_idx  = 16'(req.node_index);
  assign wr_en   = accept && (req.func == lks_pkg::FUNC_WRITE) &&
                   (32'(wr_idx) < 32'(NODE_COUNT));
  assign wr_data = '{key_high: req.key_high, key_low: req.key_low,
                     successor: req.next_index};

  // one compare unit serves every node of the walk
  assign hit     = (rd_data.key_high == key_high) && (rd_data.key_low == key_low);
  assign nxt     = rd_data.successor;
  assign head_ok = (list_head != lks_pkg::END_MARK) &&
                   (32'(list_head) < 32'(NODE_COUNT));
  assign nxt_ok  = (nxt != lks_pkg::END_MARK) && (32'(nxt) < 32'(NODE_COUNT)) &&
                   (32'(visits) < 32'(NODE_COUNT));
  assign miss    = '{found: 1'b0, found_index: lks_pkg::END_MARK,
                     prev_index: lks_pkg::END_MARK};

  // the read for the next node leaves while the current one is compared
  assign rd_addr = (state == ST_IDLE) ? list_head[AW-1:0] : nxt[AW-1:0];

  assign res.valid = (state == ST_DONE);
  assign res.rsp   = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      visits <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && (req.func == lks_pkg::FUNC_SEARCH)) begin
            key_high <= req.key_high;
            key_low  <= req.key_low;
            if (head_ok) begin
              cur    <= list_head;
              prev   <= lks_pkg::END_MARK;
              visits <= CW'(1);
              state  <= ST_VISIT;
            end else begin
              result <= miss;
              state  <= ST_DONE;
            end
          end
        end
        ST_VISIT: begin
          if (hit) begin
            result <= '{found: 1'b1, found_index: cur, prev_index: prev};
            state  <= ST_DONE;
          end else if (nxt_ok) begin
            prev   <= cur;
            cur    <= nxt;
            visits <= visits + CW'(1);
          end else begin
            result <= miss;
            state  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_found_index : assert property (@(posedge clk) disable iff (rst)
    res.valid && res.rsp.found |-> res.rsp.found_index != lks_pkg::END_MARK)
    else $error("found result without a node index");

  a_miss_marks : assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.rsp.found |->
      (res.rsp.found_index == lks_pkg::END_MARK) &&
      (res.rsp.prev_index == lks_pkg::END_MARK))
    else $error("miss result without end marks");

  a_visit_bound : assert property (@(posedge clk) disable iff (rst)
    state == ST_VISIT |-> (visits != '0) && (32'(visits) <= 32'(NODE_COUNT)))
    else $error("visit count out of range");

  a_search_starts : assert property (@(posedge clk) disable iff (rst)
    accept && (req.func == lks_pkg::FUNC_SEARCH) |=> state != ST_IDLE)
    else $error("search item dropped");

  a_write_stays_idle : assert property (@(posedge clk) disable iff (rst)
    accept && (req.func == lks_pkg::FUNC_WRITE) |=> state == ST_IDLE)
    else $error("write item started a walk");

endmodule

### hdl/indexed_list_key_search.sv
// Key search along a linked chain held in an indexed node store.
// req channel (valid/ready): func = write loads one node (keys and successor)
//   at node_index and gives no result; func = search walks the chain from
//   list_head and gives one rsp item (found, found_index, prev_index).
// APB port: register 0 at byte address 0 is list_head (0xFFFF = empty list).
//   Write it only while the block is idle.
// Timing: a write item is taken while idle and leaves the block idle. A search
//   issues the head read when it is taken, then compares one node per cycle on
//   the shared compare unit with the next read issued in the same cycle, and
//   finally hands the result to the output register. A walk visits at most
//   NODE_COUNT nodes.
// req_ready is low while a walk runs. The result sits in an output register,
//   so the next item is taken while rsp waits; a stalled rsp holds a finished
//   walk until the register frees.
// Reset (rst, synchronous) clears control state and list_head; node memory
//   is not cleared and must be written before it is reached by a walk.
module indexed_list_key_search #(
  parameter int NODE_COUNT = lks_pkg::NODE_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lks_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  lks_pkg::req_t               req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output lks_pkg::rsp_t               rsp
);

  logic [15:0]        list_head;
  lks_pkg::walk_res_t res;
  logic               res_ready;
  logic [0:0]         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      list_head <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (reg_idx == lks_pkg::REG_LIST_HEAD)) begin
      list_head <= pwdata[15:0];
    end
  end

  assign prdata = (reg_idx == lks_pkg::REG_LIST_HEAD) ? 32'(list_head) : '0;

  lks_walker #(.NODE_COUNT(NODE_COUNT)) u_walker (
    .clk       (clk),
    .rst       (rst),
    .list_head (list_head),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res       (res),
    .res_ready (res_ready)
  );

  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      rsp <= res.rsp;
    end
  end

endmodule
